// ===== sv/edc_pkg.sv =====
// Shared types, command codes and constants for the elevator dispatch controller.
package edc_pkg;

    localparam int NUM_CARS_DEF    = 2;
    localparam int FLOOR_COUNT_DEF = 16;

    localparam int CMD_W      = 3;
    localparam int CAR_ID_W   = 4;
    localparam int CAR_IDX_W  = 3;
    localparam int FLOOR_W    = 5;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int DIR_W      = 2;

    localparam logic [FLOOR_W-1:0] IDLE_BONUS   = 5'd1;
    localparam logic [FLOOR_W-1:0] AWAY_PENALTY = 5'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_FLOOR_REQ = 3'd0,
        CMD_ESTOP     = 3'd1,
        CMD_ECLEAR    = 3'd2,
        CMD_MAINT_ON  = 3'd3,
        CMD_MAINT_OFF = 3'd4,
        CMD_QUIT      = 3'd5,
        CMD_REPORT    = 3'd6,
        CMD_UNKNOWN   = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_HALTED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_MOVING = 2'd1,
        MODE_ESTOP  = 2'd2,
        MODE_MAINT  = 2'd3
    } mode_t;

    typedef enum logic [DIR_W-1:0] {
        HEAD_NONE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } heading_t;

    typedef enum logic [2:0] {
        UPD_NONE       = 3'd0,
        UPD_ASSIGN     = 3'd1,
        UPD_SET_MODE   = 3'd2,
        UPD_CLEAR_MODE = 3'd3,
        UPD_REPORT     = 3'd4
    } upd_kind_t;

    // One state change for one car, issued when a request leaves the input register.
    typedef struct packed {
        logic                 valid;
        upd_kind_t            kind;
        logic [CAR_IDX_W-1:0] car;
        logic [FLOOR_W-1:0]   floor;
        mode_t                mode;
        heading_t             heading;
        logic                 busy;
        logic                 door;
        logic                 arrived;
    } car_upd_t;

endpackage

// ===== sv/edc_dispatch.sv =====
// Car selection for a floor request: preferred car or lowest score among cars in service.
module edc_dispatch import edc_pkg::*; #(
    parameter int NUM_CARS = NUM_CARS_DEF
) (
    input  logic [FLOOR_W-1:0]                 floor,
    input  logic signed [CAR_ID_W-1:0]         pref_car,
    input  logic [NUM_CARS-1:0][FLOOR_W-1:0]   car_floor,
    input  logic [NUM_CARS-1:0][1:0]           car_mode,
    input  logic [NUM_CARS-1:0][DIR_W-1:0]     car_heading,
    output logic                               found,
    output logic [CAR_IDX_W-1:0]               chosen
);

    logic [NUM_CARS-1:0]              in_svc;
    logic [NUM_CARS-1:0][FLOOR_W-1:0] score;

    always_comb begin
        for (int c = 0; c < NUM_CARS; c++) begin
            logic [FLOOR_W-1:0] span;
            logic               away;
            in_svc[c] = (mode_t'(car_mode[c]) != MODE_ESTOP) &&
                        (mode_t'(car_mode[c]) != MODE_MAINT);
            span = (car_floor[c] > floor) ? car_floor[c] - floor : floor - car_floor[c];
            if (mode_t'(car_mode[c]) == MODE_IDLE && span != '0) begin
                span = span - IDLE_BONUS;
            end
            away = (heading_t'(car_heading[c]) == HEAD_UP && floor < car_floor[c]) ||
                   (heading_t'(car_heading[c]) == HEAD_DOWN && floor > car_floor[c]);
            score[c] = away ? span + AWAY_PENALTY : span;
        end
    end

    always_comb begin
        logic                 pref_hit;
        logic                 any;
        logic [FLOOR_W-1:0]   best;
        logic [CAR_IDX_W-1:0] best_car;
        pref_hit = 1'b0;
        any      = 1'b0;
        best     = '0;
        best_car = '0;
        for (int c = 0; c < NUM_CARS; c++) begin
            if (!pref_car[CAR_ID_W-1] && pref_car[CAR_IDX_W-1:0] == CAR_IDX_W'(c) &&
                in_svc[c]) begin
                pref_hit = 1'b1;
            end
        end
        // Strict compare keeps the lower index on a tie.
        for (int c = 0; c < NUM_CARS; c++) begin
            if (in_svc[c] && (!any || score[c] < best)) begin
                any      = 1'b1;
                best     = score[c];
                best_car = CAR_IDX_W'(c);
            end
        end
        if (pref_hit) begin
            found  = 1'b1;
            chosen = pref_car[CAR_IDX_W-1:0];
        end else begin
            found  = any;
            chosen = best_car;
        end
    end

endmodule

// ===== sv/edc_car_bank.sv =====
// Per-car state registers: floor, mode, heading, door and pending-floor map.
module edc_car_bank import edc_pkg::*; #(
    parameter int NUM_CARS    = NUM_CARS_DEF,
    parameter int FLOOR_COUNT = FLOOR_COUNT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  car_upd_t                           upd,
    output logic [NUM_CARS-1:0][FLOOR_W-1:0]   car_floor,
    output logic [NUM_CARS-1:0][1:0]           car_mode,
    output logic [NUM_CARS-1:0][DIR_W-1:0]     car_heading
);

    logic [FLOOR_COUNT-1:0] floor_bit;

    always_comb begin
        for (int f = 0; f < FLOOR_COUNT; f++) begin
            floor_bit[f] = (upd.floor == FLOOR_W'(f + 1));
        end
    end

    for (genvar c = 0; c < NUM_CARS; c++) begin : g_car
        logic [FLOOR_W-1:0]     floor_reg, floor_next;
        mode_t                  mode_reg, mode_next;
        heading_t               heading_reg, heading_next;
        logic                   door_reg, door_next;
        logic [FLOOR_COUNT-1:0] map_reg, map_next;
        logic [COUNT_W-1:0]     count_reg, count_next;
        logic                   sel;
        logic                   in_svc;
        logic                   pending;

        assign sel     = upd.valid && (upd.car == CAR_IDX_W'(c));
        assign in_svc  = (mode_reg != MODE_ESTOP) && (mode_reg != MODE_MAINT);
        assign pending = |(map_reg & floor_bit);

        always_comb begin
            floor_next   = floor_reg;
            mode_next    = mode_reg;
            heading_next = heading_reg;
            door_next    = door_reg;
            map_next     = map_reg;
            count_next   = count_reg;
            if (sel) begin
                case (upd.kind)
                    UPD_ASSIGN: begin
                        if (!pending) begin
                            map_next   = map_reg | floor_bit;
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end
                    UPD_SET_MODE: begin
                        mode_next    = upd.mode;
                        door_next    = 1'b0;
                        heading_next = HEAD_NONE;
                    end
                    UPD_CLEAR_MODE: begin
                        if (mode_reg == upd.mode) begin
                            mode_next    = MODE_IDLE;
                            heading_next = HEAD_NONE;
                        end
                    end
                    UPD_REPORT: begin
                        floor_next = upd.floor;
                        door_next  = upd.door;
                        // A car out of service keeps its mode and heading.
                        if (in_svc) begin
                            mode_next    = upd.busy ? MODE_MOVING : MODE_IDLE;
                            heading_next = upd.heading;
                        end
                        if (upd.arrived && pending) begin
                            map_next   = map_reg & ~floor_bit;
                            count_next = count_reg - COUNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                floor_reg   <= FLOOR_W'(1);
                mode_reg    <= MODE_IDLE;
                heading_reg <= HEAD_NONE;
                door_reg    <= 1'b0;
                map_reg     <= '0;
                count_reg   <= '0;
            end else begin
                floor_reg   <= floor_next;
                mode_reg    <= mode_next;
                heading_reg <= heading_next;
                door_reg    <= door_next;
                map_reg     <= map_next;
                count_reg   <= count_next;
            end
        end

        assign car_floor[c]   = floor_reg;
        assign car_mode[c]    = mode_reg;
        assign car_heading[c] = heading_reg;
    end

endmodule

// ===== sv/elevator_dispatch_controller.sv =====
// Top level of the elevator dispatch controller: input register, decode and result register.
// A request is held in the input register, and its result is registered onto the m_ ports as it leaves.
// Throughput: one request per cycle unless a result is held back by m_ready; the car state updates
// as the request leaves the input register, so the following request already sees it.
// Reset (synchronous, aresetn low): all cars at floor one, idle, no heading, door closed,
// nothing pending, block not halted, both registers empty.
module elevator_dispatch_controller import edc_pkg::*; #(
    parameter int NUM_CARS    = NUM_CARS_DEF,
    parameter int FLOOR_COUNT = FLOOR_COUNT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CMD_W-1:0]           s_command,
    input  logic signed [CAR_ID_W-1:0] s_car_id,
    input  logic [FLOOR_W-1:0]         s_dest_floor,
    input  logic [FLOOR_W-1:0]         s_report_floor,
    input  logic [DIR_W-1:0]           s_report_direction,
    input  logic                       s_report_busy,
    input  logic                       s_report_door_open,
    input  logic                       s_report_arrived,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [CAR_ID_W-1:0] m_assigned_car
);

    logic                       in_valid_reg;
    logic [CMD_W-1:0]           command_reg;
    logic signed [CAR_ID_W-1:0] car_id_reg;
    logic [FLOOR_W-1:0]         dest_floor_reg;
    logic [FLOOR_W-1:0]         report_floor_reg;
    logic [DIR_W-1:0]           report_direction_reg;
    logic                       report_busy_reg;
    logic                       report_door_open_reg;
    logic                       report_arrived_reg;

    logic                       halted_reg, halted_next;
    logic                       out_valid_reg;
    status_t                    status_reg, status_next;
    logic signed [CAR_ID_W-1:0] assigned_reg, assigned_next;

    logic                             proceed;
    logic                             id_ok;
    logic                             target_ok;
    logic                             report_ok;
    logic                             found;
    logic [CAR_IDX_W-1:0]             chosen;
    car_upd_t                         upd;
    logic [NUM_CARS-1:0][FLOOR_W-1:0] car_floor;
    logic [NUM_CARS-1:0][1:0]         car_mode;
    logic [NUM_CARS-1:0][DIR_W-1:0]   car_heading;

    assign proceed = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proceed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            command_reg          <= s_command;
            car_id_reg           <= s_car_id;
            dest_floor_reg       <= s_dest_floor;
            report_floor_reg     <= s_report_floor;
            report_direction_reg <= s_report_direction;
            report_busy_reg      <= s_report_busy;
            report_door_open_reg <= s_report_door_open;
            report_arrived_reg   <= s_report_arrived;
        end
    end

    assign id_ok = !car_id_reg[CAR_ID_W-1] &&
                   ({1'b0, car_id_reg[CAR_IDX_W-1:0]} < CAR_ID_W'(NUM_CARS));
    assign target_ok = (dest_floor_reg != '0) && (dest_floor_reg <= FLOOR_W'(FLOOR_COUNT));
    assign report_ok = (report_floor_reg != '0) && (report_floor_reg <= FLOOR_W'(FLOOR_COUNT));

    edc_dispatch #(
        .NUM_CARS (NUM_CARS)
    ) u_dispatch (
        .floor       (dest_floor_reg),
        .pref_car    (car_id_reg),
        .car_floor   (car_floor),
        .car_mode    (car_mode),
        .car_heading (car_heading),
        .found       (found),
        .chosen      (chosen)
    );

    always_comb begin
        status_next   = ST_OK;
        assigned_next = -4'sd1;
        halted_next   = halted_reg;

        upd         = '0;
        upd.kind    = UPD_NONE;
        upd.mode    = MODE_IDLE;
        upd.heading = (report_direction_reg == HEAD_UP || report_direction_reg == HEAD_DOWN)
                      ? heading_t'(report_direction_reg) : HEAD_NONE;
        upd.floor   = report_floor_reg;
        upd.car     = car_id_reg[CAR_IDX_W-1:0];
        upd.busy    = report_busy_reg;
        upd.door    = report_door_open_reg;
        upd.arrived = report_arrived_reg;

        if (halted_reg) begin
            status_next = ST_HALTED;
        end else begin
            case (cmd_t'(command_reg))
                CMD_FLOOR_REQ: begin
                    if (target_ok && found) begin
                        upd.kind      = UPD_ASSIGN;
                        upd.car       = chosen;
                        upd.floor     = dest_floor_reg;
                        assigned_next = CAR_ID_W'({1'b0, chosen});
                    end else begin
                        status_next = ST_REJECT;
                    end
                end
                CMD_QUIT: begin
                    halted_next = 1'b1;
                end
                CMD_ESTOP, CMD_MAINT_ON: begin
                    if (id_ok) begin
                        upd.kind = UPD_SET_MODE;
                        upd.mode = (cmd_t'(command_reg) == CMD_ESTOP) ? MODE_ESTOP : MODE_MAINT;
                    end else begin
                        status_next = ST_REJECT;
                    end
                end
                CMD_ECLEAR, CMD_MAINT_OFF: begin
                    if (id_ok) begin
                        upd.kind = UPD_CLEAR_MODE;
                        upd.mode = (cmd_t'(command_reg) == CMD_ECLEAR) ? MODE_ESTOP : MODE_MAINT;
                    end else begin
                        status_next = ST_REJECT;
                    end
                end
                CMD_REPORT: begin
                    if (id_ok && report_ok) begin
                        upd.kind = UPD_REPORT;
                    end else begin
                        status_next = ST_REJECT;
                    end
                end
                default: begin
                    status_next = ST_REJECT;
                end
            endcase
        end
        upd.valid = proceed && (upd.kind != UPD_NONE);
    end

    edc_car_bank #(
        .NUM_CARS    (NUM_CARS),
        .FLOOR_COUNT (FLOOR_COUNT)
    ) u_car_bank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .upd         (upd),
        .car_floor   (car_floor),
        .car_mode    (car_mode),
        .car_heading (car_heading)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (proceed) begin
                halted_reg <= halted_next;
            end
            if (proceed) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed) begin
            status_reg   <= status_next;
            assigned_reg <= assigned_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_assigned_car = assigned_reg;

endmodule

// ===== sv/edc_checker.sv =====
// Port-level checks for the elevator dispatch controller, bound to the top level.
module edc_checker import edc_pkg::*; #(
    parameter int NUM_CARS = NUM_CARS_DEF
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [STATUS_W-1:0]        m_status,
    input logic signed [CAR_ID_W-1:0] m_assigned_car
);

    // A result that is held back keeps its value.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_assigned_car))
        else $error("result changed while stalled");

    // Only an accepted floor request names a car.
    a_car_only_when_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_assigned_car == -4'sd1)
        else $error("car assigned on a refused request");

    a_car_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_assigned_car != -4'sd1 |->
            !m_assigned_car[CAR_ID_W-1] &&
            ({1'b0, m_assigned_car[CAR_IDX_W-1:0]} < CAR_ID_W'(NUM_CARS)))
        else $error("assigned car out of range");

    // The input side stalls only behind a result that is waiting to be taken.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with the result side free");

endmodule

bind elevator_dispatch_controller edc_checker #(
    .NUM_CARS (NUM_CARS)
) u_edc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_assigned_car (m_assigned_car)
);

// ===== test/tb.sv =====
// Self-checking testbench for the elevator dispatch controller: random and directed requests.
module tb;
    import edc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CARS    = NUM_CARS_DEF;
    localparam int FLOOR_COUNT = FLOOR_COUNT_DEF;
    localparam int RANDOM_REQS = 1915;
    localparam int HOLD_START  = 500;
    localparam int HOLD_CYCLES = 400;
    localparam logic [DIR_W-1:0] DIR_RESERVED = 2'd3;

    typedef struct {
        cmd_t                       cmd;
        logic signed [CAR_ID_W-1:0] car_id;
        logic [FLOOR_W-1:0]         dest_floor;
        logic [FLOOR_W-1:0]         report_floor;
        logic [DIR_W-1:0]           report_direction;
        logic                       report_busy;
        logic                       report_door_open;
        logic                       report_arrived;
    } dispatch_req_t;

    typedef struct {
        status_t                    status;
        logic signed [CAR_ID_W-1:0] car;
    } dispatch_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_command = CMD_UNKNOWN;
    logic signed [CAR_ID_W-1:0] s_car_id = '0;
    logic [FLOOR_W-1:0]         s_dest_floor = '0;
    logic [FLOOR_W-1:0]         s_report_floor = '0;
    logic [DIR_W-1:0]           s_report_direction = '0;
    logic                       s_report_busy = 1'b0;
    logic                       s_report_door_open = 1'b0;
    logic                       s_report_arrived = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [STATUS_W-1:0]        m_status;
    logic signed [CAR_ID_W-1:0] m_assigned_car;

    // Shadow copy of the car group.
    logic [FLOOR_W-1:0]     car_floor_q [NUM_CARS];
    mode_t                  car_mode_q  [NUM_CARS];
    heading_t               car_head_q  [NUM_CARS];
    logic                   door_q      [NUM_CARS];
    logic [FLOOR_COUNT-1:0] pend_map    [NUM_CARS];
    logic [COUNT_W-1:0]     pend_cnt    [NUM_CARS];
    logic                   halted_q;

    dispatch_req_t    pending_reqs [$];
    dispatch_result_t expected_results [$];
    dispatch_req_t    offered;
    int               total_reqs;
    int               accepted_reqs = 0;
    int               mismatch_count = 0;
    int               burst_left = 0;
    int               gap_left = 0;
    int               phase_left = 0;
    int               stall_kind = 0;
    int               cycle_no = 0;
    logic             long_hold = 1'b0;

    elevator_dispatch_controller #(
        .NUM_CARS    (NUM_CARS),
        .FLOOR_COUNT (FLOOR_COUNT)
    ) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_car_id           (s_car_id),
        .s_dest_floor       (s_dest_floor),
        .s_report_floor     (s_report_floor),
        .s_report_direction (s_report_direction),
        .s_report_busy      (s_report_busy),
        .s_report_door_open (s_report_door_open),
        .s_report_arrived   (s_report_arrived),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_assigned_car     (m_assigned_car)
    );

    always #1 aclk = ~aclk;

    function automatic dispatch_req_t make_request(input cmd_t cmd, input int id, input int tf,
                                                   input int rf, input logic [DIR_W-1:0] dir,
                                                   input logic busy, input logic door,
                                                   input logic arrived);
        dispatch_req_t rq;
        rq.cmd              = cmd;
        rq.car_id           = CAR_ID_W'(id);
        rq.dest_floor       = FLOOR_W'(tf);
        rq.report_floor     = FLOOR_W'(rf);
        rq.report_direction = dir;
        rq.report_busy      = busy;
        rq.report_door_open = door;
        rq.report_arrived   = arrived;
        return rq;
    endfunction

    function automatic logic car_in_service(input int c);
        return car_mode_q[c] != MODE_ESTOP && car_mode_q[c] != MODE_MAINT;
    endfunction

    // Applies one request to the shadow state and returns the answer the block should give.
    function automatic dispatch_result_t predict_dispatch(input dispatch_req_t rq);
        dispatch_result_t       res;
        int                     id, flr, rflr, best, lowest_score, here, score, c;
        logic                   id_ok;
        logic [FLOOR_COUNT-1:0] fmask;
        res.status = ST_OK;
        res.car    = -4'sd1;
        id    = int'(rq.car_id);
        flr   = int'(rq.dest_floor);
        rflr  = int'(rq.report_floor);
        id_ok = id >= 0 && id < NUM_CARS;
        if (halted_q) begin
            res.status = ST_HALTED;
        end else if (rq.cmd == CMD_FLOOR_REQ) begin
            if (flr < 1 || flr > FLOOR_COUNT) begin
                res.status = ST_REJECT;
            end else begin
                best = -1;
                if (id_ok && car_in_service(id)) begin
                    best = id;
                end else begin
                    lowest_score = FLOOR_COUNT + 10;
                    for (c = 0; c < NUM_CARS; c++) begin
                        if (car_in_service(c)) begin
                            here  = int'(car_floor_q[c]);
                            score = here > flr ? here - flr : flr - here;
                            if (car_mode_q[c] == MODE_IDLE)
                                score = score > 0 ? score - int'(IDLE_BONUS) : 0;
                            if ((car_head_q[c] == HEAD_UP && flr < here) ||
                                (car_head_q[c] == HEAD_DOWN && flr > here))
                                score = score + int'(AWAY_PENALTY);
                            if (score < lowest_score) begin
                                lowest_score = score;
                                best         = c;
                            end
                        end
                    end
                end
                if (best < 0) begin
                    res.status = ST_REJECT;
                end else begin
                    fmask = FLOOR_COUNT'(1) << (flr - 1);
                    if ((pend_map[best] & fmask) == '0) begin
                        pend_map[best] = pend_map[best] | fmask;
                        pend_cnt[best] = pend_cnt[best] + 1'b1;
                    end
                    res.car = CAR_ID_W'(best);
                end
            end
        end else if (rq.cmd == CMD_QUIT) begin
            halted_q = 1'b1;
        end else if (rq.cmd == CMD_UNKNOWN || !id_ok) begin
            res.status = ST_REJECT;
        end else if (rq.cmd == CMD_ESTOP || rq.cmd == CMD_MAINT_ON) begin
            car_mode_q[id] = rq.cmd == CMD_ESTOP ? MODE_ESTOP : MODE_MAINT;
            door_q[id]     = 1'b0;
            car_head_q[id] = HEAD_NONE;
        end else if (rq.cmd == CMD_ECLEAR || rq.cmd == CMD_MAINT_OFF) begin
            if (car_mode_q[id] == (rq.cmd == CMD_ECLEAR ? MODE_ESTOP : MODE_MAINT)) begin
                car_mode_q[id] = MODE_IDLE;
                car_head_q[id] = HEAD_NONE;
            end
        end else begin
            if (rflr < 1 || rflr > FLOOR_COUNT) begin
                res.status = ST_REJECT;
            end else begin
                fmask           = FLOOR_COUNT'(1) << (rflr - 1);
                car_floor_q[id] = rq.report_floor;
                door_q[id]      = rq.report_door_open;
                // A car out of service keeps its mode and heading whatever it reports.
                if (car_in_service(id)) begin
                    car_mode_q[id] = rq.report_busy ? MODE_MOVING : MODE_IDLE;
                    car_head_q[id] = rq.report_direction == DIR_RESERVED
                                     ? HEAD_NONE : heading_t'(rq.report_direction);
                end
                if (rq.report_arrived && (pend_map[id] & fmask) != '0) begin
                    pend_map[id] = pend_map[id] & ~fmask;
                    pend_cnt[id] = pend_cnt[id] - 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic record_error(input string msg);
        if (mismatch_count < 10)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // Sender: bursts of requests separated by random gaps.
    always @(posedge aclk) begin : driver
        dispatch_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_dispatch(offered));
                accepted_reqs++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    nxt = pending_reqs.pop_front();
                    offered            <= nxt;
                    s_valid            <= 1'b1;
                    s_command          <= nxt.cmd;
                    s_car_id           <= nxt.car_id;
                    s_dest_floor       <= nxt.dest_floor;
                    s_report_floor     <= nxt.report_floor;
                    s_report_direction <= nxt.report_direction;
                    s_report_busy      <= nxt.report_busy;
                    s_report_door_open <= nxt.report_door_open;
                    s_report_arrived   <= nxt.report_arrived;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off on the result side so that the block backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cycle_no  <= 0;
            long_hold <= 1'b0;
        end else begin
            cycle_no  <= cycle_no + 1;
            long_hold <= cycle_no >= HOLD_START && cycle_no < HOLD_START + HOLD_CYCLES;
        end
    end

    // Receiver: checks each result and stalls in phases of varying density.
    always @(posedge aclk) begin : monitor
        dispatch_result_t want;
        logic             go;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    record_error($sformatf("result with no request outstanding: status %0d car %0d",
                                           m_status, m_assigned_car));
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        record_error($sformatf("status: expected %0d, got %0d",
                                               want.status, m_status));
                    if (m_assigned_car !== want.car)
                        record_error($sformatf("assigned car: expected %0d, got %0d",
                                               want.car, m_assigned_car));
                end
            end
            if (phase_left == 0) begin
                stall_kind <= $urandom_range(0, 2);
                phase_left <= $urandom_range(20, 200);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (stall_kind)
                0:       go = 1'b1;
                1:       go = $urandom_range(0, 3) != 0;
                default: go = $urandom_range(0, 3) == 0;
            endcase
            m_ready <= go && !long_hold;
        end
    end

    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        dispatch_req_t rq;
        int            k, sel, v;
        for (int c = 0; c < NUM_CARS; c++) begin
            car_floor_q[c] = FLOOR_W'(1);
            car_mode_q[c]  = MODE_IDLE;
            car_head_q[c]  = HEAD_NONE;
            door_q[c]      = 1'b0;
            pend_map[c]    = '0;
            pend_cnt[c]    = '0;
        end
        halted_q = 1'b0;

        // Invalid floors, ties, preferences and a floor that is already pending.
        pending_reqs.push_back(make_request(CMD_FLOOR_REQ, -1, 0, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_FLOOR_REQ, -1, 17, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_FLOOR_REQ, 0, 31, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_FLOOR_REQ, -1, 1, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_FLOOR_REQ, 1, 16, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_FLOOR_REQ, 1, 16, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_FLOOR_REQ, 7, 8, 1, HEAD_NONE, 0, 0, 0));
        // Position reports, including the reserved direction and out-of-range floors.
        pending_reqs.push_back(make_request(CMD_REPORT, 0, 0, 10, HEAD_UP, 1, 1, 0));
        pending_reqs.push_back(make_request(CMD_REPORT, 1, 0, 3, DIR_RESERVED, 0, 0, 1));
        pending_reqs.push_back(make_request(CMD_REPORT, 1, 0, 16, HEAD_DOWN, 1, 0, 1));
        pending_reqs.push_back(make_request(CMD_REPORT, 0, 0, 0, HEAD_UP, 1, 1, 1));
        pending_reqs.push_back(make_request(CMD_REPORT, 0, 0, 17, HEAD_UP, 1, 1, 1));
        pending_reqs.push_back(make_request(CMD_REPORT, 1, 0, 31, HEAD_DOWN, 0, 1, 0));
        pending_reqs.push_back(make_request(CMD_FLOOR_REQ, -1, 2, 1, HEAD_NONE, 0, 0, 0));
        // Emergency and maintenance, a report on a car out of service, no car available.
        pending_reqs.push_back(make_request(CMD_ESTOP, 0, 0, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_FLOOR_REQ, 0, 5, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_REPORT, 0, 0, 4, HEAD_UP, 1, 1, 0));
        pending_reqs.push_back(make_request(CMD_ECLEAR, 1, 0, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_MAINT_OFF, 0, 0, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_MAINT_ON, 1, 0, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_FLOOR_REQ, -1, 9, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_ECLEAR, 0, 0, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_MAINT_OFF, 1, 0, 1, HEAD_NONE, 0, 0, 0));
        // Car ids that name no car, and an unknown command.
        pending_reqs.push_back(make_request(CMD_ESTOP, -1, 0, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_MAINT_ON, 2, 0, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_REPORT, 7, 0, 5, HEAD_UP, 1, 1, 1));
        pending_reqs.push_back(make_request(CMD_ECLEAR, -8, 0, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_UNKNOWN, 0, 3, 3, HEAD_NONE, 0, 0, 0));

        // Mostly requests and reports on real cars, with some mode changes and noise.
        repeat (RANDOM_REQS) begin
            sel = $urandom_range(0, 9);
            if (sel <= 5)
                v = $urandom_range(0, NUM_CARS - 1);
            else if (sel <= 7)
                v = -1;
            else if (sel == 8)
                v = $urandom_range(NUM_CARS, 7);
            else
                v = -int'($urandom_range(2, 8));
            rq = make_request(CMD_UNKNOWN, v, $urandom_range(1, FLOOR_COUNT),
                              $urandom_range(1, FLOOR_COUNT), DIR_W'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            if ($urandom_range(0, 19) == 0) begin
                v = $urandom_range(0, 15);
                rq.dest_floor = v == 0 ? '0 : FLOOR_W'(FLOOR_COUNT + v);
            end
            if ($urandom_range(0, 19) == 0) begin
                v = $urandom_range(0, 15);
                rq.report_floor = v == 0 ? '0 : FLOOR_W'(FLOOR_COUNT + v);
            end
            k = $urandom_range(0, 99);
            if (k < 40)
                rq.cmd = CMD_FLOOR_REQ;
            else if (k < 72)
                rq.cmd = CMD_REPORT;
            else if (k < 78)
                rq.cmd = CMD_ESTOP;
            else if (k < 86)
                rq.cmd = CMD_ECLEAR;
            else if (k < 91)
                rq.cmd = CMD_MAINT_ON;
            else if (k < 97)
                rq.cmd = CMD_MAINT_OFF;
            else
                rq.cmd = CMD_UNKNOWN;
            pending_reqs.push_back(rq);
        end

        // Quit last, since it halts the block until reset; then a few requests it must refuse.
        pending_reqs.push_back(make_request(CMD_QUIT, $urandom_range(0, 7), 0, 1, HEAD_NONE,
                                            0, 0, 0));
        pending_reqs.push_back(make_request(CMD_FLOOR_REQ, 0, 4, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_REPORT, 1, 0, 6, HEAD_UP, 1, 0, 1));
        pending_reqs.push_back(make_request(CMD_QUIT, -1, 0, 1, HEAD_NONE, 0, 0, 0));
        pending_reqs.push_back(make_request(CMD_UNKNOWN, 0, 0, 1, HEAD_NONE, 0, 0, 0));
        total_reqs = pending_reqs.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Sampled on the falling edge, once the rising-edge updates have settled.
        while (accepted_reqs < total_reqs || expected_results.size() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
